// File: hdl/rrd_pkg.sv
// Shared types, codes and helpers for the four-queue round-robin drain block.
// No dependencies; imported by rrd_ctrl, rrd_dp and the top level.
package rrd_pkg;

  localparam int NUM_Q           = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 32;
  localparam int OUT_ID_W        = 32;

  // queue codes as seen on from_queue
  localparam logic [1:0] Q_WEST  = 2'd0;
  localparam logic [1:0] Q_NORTH = 2'd1;
  localparam logic [1:0] Q_SOUTH = 2'd2;
  localparam logic [1:0] Q_EAST  = 2'd3;

  // result status codes
  localparam logic [1:0] ST_DRAINED = 2'd0;
  localparam logic [1:0] ST_DROPPED = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;

  // request types
  localparam logic REQ_NUMBER = 1'b0;
  localparam logic REQ_ITEM   = 1'b1;

  // queue number tokens
  localparam logic signed [3:0] QN_EAST  = -4'sd4;
  localparam logic signed [3:0] QN_NORTH = -4'sd3;
  localparam logic signed [3:0] QN_SOUTH = -4'sd2;
  localparam logic signed [3:0] QN_DRAIN = 4'sd0;

  // commands from the controller to the datapath
  typedef struct packed {
    logic push;
    logic select;
    logic drain_empty;
    logic pop;
  } rrd_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic total_zero;
    logic last_pop;
  } rrd_sts_t;

  function automatic logic [1:0] sel_queue(logic signed [3:0] qn);
    logic [1:0] q;
    unique case (qn)
      QN_EAST:  q = Q_EAST;
      QN_NORTH: q = Q_NORTH;
      QN_SOUTH: q = Q_SOUTH;
      default:  q = Q_WEST;
    endcase
    return q;
  endfunction

endpackage

// File: hdl/rrd_ctrl.sv
// Controller FSM: decodes accepted transactions into datapath commands and
// sequences the drain. Depends on rrd_pkg.
module rrd_ctrl
  import rrd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                req_type_i,
  input  logic signed [3:0]   queue_number_i,
  input  rrd_sts_t            sts_i,
  output rrd_cmd_t            cmd_o,
  output logic                busy_o
);

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_e;

  state_e state_q, state_d;
  logic   take;
  logic   is_drain;

  assign take     = start_i && (state_q == S_IDLE);
  assign is_drain = (queue_number_i == QN_DRAIN);
  assign busy_o   = (state_q == S_DRAIN);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          if (req_type_i == REQ_ITEM) begin
            cmd_o.push = 1'b1;
          end else if (!is_drain) begin
            cmd_o.select = 1'b1;
          end else if (sts_i.total_zero) begin
            cmd_o.drain_empty = 1'b1;
          end else begin
            state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        cmd_o.pop = 1'b1;
        if (sts_i.last_pop) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hdl/rrd_dp.sv
// Datapath: queue memory, per-queue pointers and counts, selector,
// round-robin pick and result registers. Depends on rrd_pkg.
module rrd_dp
  import rrd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rrd_cmd_t              cmd_i,
  input  logic signed [3:0]     queue_number_i,
  input  logic [OUT_ID_W-1:0]   item_id_i,
  output rrd_sts_t              sts_o,
  output logic                  result_valid_o,
  output logic [OUT_ID_W-1:0]   out_id_o,
  output logic [1:0]            from_queue_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);

  localparam int SLOT_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_D  = NUM_Q * QUEUE_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);
  localparam int TOT_W  = $clog2(MEM_D + 1);

  logic [ID_BITS-1:0] mem_q [MEM_D];
  logic [ID_BITS-1:0] rd_q;

  logic [SLOT_W-1:0] head_q [NUM_Q];
  logic [SLOT_W-1:0] tail_q [NUM_Q];
  logic [CNT_W-1:0]  cnt_q  [NUM_Q];
  logic [TOT_W-1:0]  total_q;
  logic [1:0]        cur_q;
  logic [1:0]        rr_q;

  logic                valid_q;
  logic                from_mem_q;
  logic [OUT_ID_W-1:0] hold_q;
  logic [1:0]          from_q;
  logic [1:0]          status_q;
  logic                last_q;

  logic [1:0]        pick;
  logic              full;
  logic              do_write;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [63:0]       rd_ext;

  // first nonempty queue at or after the round-robin pointer
  always_comb begin
    logic       found;
    logic [1:0] idx;
    found = 1'b0;
    pick  = rr_q;
    for (int i = 0; i < NUM_Q; i++) begin
      idx = rr_q + 2'(i);
      if (!found && cnt_q[idx] != '0) begin
        found = 1'b1;
        pick  = idx;
      end
    end
  end

  assign full     = (cnt_q[cur_q] == CNT_W'(QUEUE_DEPTH));
  assign do_write = cmd_i.push && !full;
  assign waddr    = ADDR_W'(cur_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail_q[cur_q]);
  assign raddr    = ADDR_W'(pick) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head_q[pick]);

  assign sts_o.total_zero = (total_q == '0);
  assign sts_o.last_pop   = (total_q == TOT_W'(1));

  always_ff @(posedge clk_i) begin
    if (do_write) mem_q[waddr] <= ID_BITS'(item_id_i);
    if (cmd_i.pop) rd_q <= mem_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_Q; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
      total_q <= '0;
      cur_q   <= Q_EAST;
      rr_q    <= Q_WEST;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.pop || cmd_i.drain_empty || (cmd_i.push && full);
      if (cmd_i.select) cur_q <= sel_queue(queue_number_i);
      if (cmd_i.drain_empty) cur_q <= Q_EAST;
      if (do_write) begin
        tail_q[cur_q] <= (tail_q[cur_q] == SLOT_W'(QUEUE_DEPTH - 1)) ?
                         '0 : tail_q[cur_q] + SLOT_W'(1);
        cnt_q[cur_q]  <= cnt_q[cur_q] + CNT_W'(1);
        total_q       <= total_q + TOT_W'(1);
      end
      if (cmd_i.pop) begin
        head_q[pick] <= (head_q[pick] == SLOT_W'(QUEUE_DEPTH - 1)) ?
                        '0 : head_q[pick] + SLOT_W'(1);
        cnt_q[pick]  <= cnt_q[pick] - CNT_W'(1);
        total_q      <= total_q - TOT_W'(1);
        if (sts_o.last_pop) begin
          rr_q  <= Q_WEST;
          cur_q <= Q_EAST;
        end else begin
          rr_q <= pick + 2'd1;
        end
      end
    end
  end

  // result side info; id comes from memory for drains, else from hold_q
  always_ff @(posedge clk_i) begin
    if (cmd_i.pop) begin
      from_mem_q <= 1'b1;
      from_q     <= pick;
      status_q   <= ST_DRAINED;
      last_q     <= sts_o.last_pop;
    end else if (cmd_i.drain_empty) begin
      from_mem_q <= 1'b0;
      hold_q     <= '0;
      from_q     <= Q_WEST;
      status_q   <= ST_EMPTY;
      last_q     <= 1'b1;
    end else if (cmd_i.push && full) begin
      from_mem_q <= 1'b0;
      hold_q     <= OUT_ID_W'(64'(ID_BITS'(item_id_i)));
      from_q     <= cur_q;
      status_q   <= ST_DROPPED;
      last_q     <= 1'b1;
    end
  end

  assign rd_ext         = 64'(rd_q);
  assign result_valid_o = valid_q;
  assign out_id_o       = from_mem_q ? rd_ext[OUT_ID_W-1:0] : hold_q;
  assign from_queue_o   = from_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

endmodule

// File: hdl/four_queue_round_robin_drain.sv
// Four-queue round-robin drain, top level. Instantiates rrd_ctrl and rrd_dp;
// depends on rrd_pkg.
//
// A transaction is taken on a clock edge with start high and busy low.
// Queue selects and pushes do not raise busy, so they can be issued every
// cycle. A push into a full queue yields one result (status dropped) on the
// cycle after it is taken. A drain token with all queues empty yields one
// "empty" result in the cycle after it is taken and does not raise busy. A
// drain of N stored identifiers holds busy high until its last pop, one pop per cycle,
// set by the single read port of the shared queue memory; each result follows
// its pop in the next cycle through the registered memory read. Every result is
// valid for exactly one cycle on result_valid_o and cannot be stalled.
// The queue memory has no reset; entries are only read after being written.
module four_queue_round_robin_drain
  import rrd_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic                  req_type_i,
  input  logic signed [3:0]     queue_number_i,
  input  logic [OUT_ID_W-1:0]   item_id_i,
  output logic                  result_valid_o,
  output logic [OUT_ID_W-1:0]   out_id_o,
  output logic [1:0]            from_queue_o,
  output logic [1:0]            status_o,
  output logic                  last_o
);

  rrd_cmd_t cmd;
  rrd_sts_t sts;

  rrd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .req_type_i     (req_type_i),
    .queue_number_i (queue_number_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy)
  );

  rrd_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .queue_number_i (queue_number_i),
    .item_id_i      (item_id_i),
    .sts_o          (sts),
    .result_valid_o (result_valid_o),
    .out_id_o       (out_id_o),
    .from_queue_o   (from_queue_o),
    .status_o       (status_o),
    .last_o         (last_o)
  );

endmodule
